// ----- design/positional_list_engine_macros.svh -----
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// request and result types, operation and status codes, cell commands
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  typedef enum logic [2:0] {
    OpInsFirst = 3'd0,
    OpInsLast  = 3'd1,
    OpInsAt    = 3'd2,
    OpDelFirst = 3'd3,
    OpDelLast  = 3'd4,
    OpDelAt    = 3'd5,
    OpReadout  = 3'd6,
    OpCount    = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadPos = 2'd1,
    StFull   = 2'd2,
    StEmpty  = 2'd3
  } status_e;

  // command broadcast to every cell
  typedef enum logic [1:0] {
    CellHold = 2'd0,
    CellIns  = 2'd1,
    CellDel  = 2'd2,
    CellRot  = 2'd3
  } cell_op_e;

  typedef struct packed {
    opcode_e            operation;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] element;
    logic [6:0]         element_count;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds, loads, or takes a neighbour's word per command
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 6,
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk_i,
  input  ple_pkg::cell_op_e      op_i,
  input  wire  [IDX_W-1:0]       idx_i,
  input  wire  [DATA_WIDTH-1:0]  ins_data_i,
  input  wire  [DATA_WIDTH-1:0]  head_data_i,
  input  wire  [DATA_WIDTH-1:0]  left_i,
  input  wire  [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0]  data_o
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  below, at;

  assign below = MyIdx < idx_i;
  assign at    = MyIdx == idx_i;

  always_comb begin
    data_d = data_q;
    unique case (op_i)
      CellHold: data_d = data_q;
      CellIns: begin
        if (at) begin
          data_d = ins_data_i;
        end else if (!below) begin
          data_d = left_i;
        end
      end
      CellDel: begin
        if (!below) begin
          data_d = right_i;
        end
      end
      CellRot: begin
        // rotate the occupied part one place towards the head
        if (below) begin
          data_d = right_i;
        end else if (at) begin
          data_d = head_data_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- design/ple_chain.sv -----
// ----------------------------------------------------------------------------
// ple_chain
// row of list cells wired to their neighbours, head word brought out
// ----------------------------------------------------------------------------
`default_nettype none

module ple_chain #(
  parameter int CAPACITY   = 64,
  parameter int IDX_W      = 6,
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk_i,
  input  ple_pkg::cell_op_e      op_i,
  input  wire  [IDX_W-1:0]       idx_i,
  input  wire  [DATA_WIDTH-1:0]  ins_data_i,
  output logic [DATA_WIDTH-1:0]  head_data_o
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = ins_data_i;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    ple_cell #(
      .INDEX      (g),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op_i),
      .idx_i       (idx_i),
      .ins_data_i  (ins_data_i),
      .head_data_i (cell_data[0]),
      .left_i      (left),
      .right_i     (right),
      .data_o      (cell_data[g])
    );
  end

  assign head_data_o = cell_data[0];

endmodule

`default_nettype wire

// ----- design/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// result: registered in the cycle after the request is taken, for all operations but a read-out of a non-empty list
// throughput: one request per cycle for insert, delete and count while the output is not stalled and no read-out runs
// read-out: one element per cycle while the output is not stalled, each taken from the head cell
// reset: list empty, no result pending, cell contents undefined until written
// ----------------------------------------------------------------------------
`default_nettype none
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  ple_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output ple_pkg::res_t   out_res_o
);
  import ple_pkg::*;

  // count needs to hold capacity itself, a slot index only capacity - 1
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  // compare width wide enough for both the position field and the count
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

  // list state
  logic [CNT_W-1:0] count_q, count_d;
  logic             busy_q;
  logic [CNT_W-1:0] rd_left_q;

  // output register
  logic             out_valid_q;
  res_t             out_q;

  // handshake
  logic can_load, acc, step;

  // decode of the incoming request
  logic [CMP_W-1:0] pos_w, cnt_w;
  logic             full, empty, ins_bad, del_bad;
  status_e          req_st;
  cell_op_e         req_op;
  logic [IDX_W-1:0] req_idx;

  // command to the chain
  cell_op_e         cell_op;
  logic [IDX_W-1:0] cell_idx;
  logic [DATA_WIDTH-1:0] ins_data, head_data;
  logic signed [DATA_WIDTH-1:0] head_s;

  // output register can take a new result when empty or being drained
  assign can_load   = !out_valid_q || !out_stall_i;
  // one read-out at a time, and every request waits while it runs; other requests do not set busy
  assign in_stall_o = busy_q || !can_load;
  assign acc        = in_valid_i && !in_stall_o;
  assign step       = busy_q && can_load;

  assign pos_w   = CMP_W'(in_req_i.position);
  assign cnt_w   = CMP_W'(count_q);
  assign full    = count_q == CNT_W'(CAPACITY);
  assign empty   = count_q == '0;
  assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + 1'b1);
  assign del_bad = (pos_w == '0) || (pos_w > cnt_w);

  // status and shift command per operation; the position check wins over full
  always_comb begin
    req_st  = StOk;
    req_op  = CellHold;
    req_idx = '0;
    unique case (in_req_i.operation)
      OpInsFirst: begin
        if (full) begin
          req_st = StFull;
        end else begin
          req_op = CellIns;
        end
      end
      OpInsLast: begin
        if (full) begin
          req_st = StFull;
        end else begin
          req_op  = CellIns;
          req_idx = IDX_W'(count_q);
        end
      end
      OpInsAt: begin
        if (ins_bad) begin
          req_st = StBadPos;
        end else if (full) begin
          req_st = StFull;
        end else begin
          req_op  = CellIns;
          req_idx = IDX_W'(pos_w - 1'b1);
        end
      end
      OpDelFirst: begin
        if (empty) begin
          req_st = StEmpty;
        end else begin
          req_op = CellDel;
        end
      end
      OpDelLast: begin
        if (empty) begin
          req_st = StEmpty;
        end else begin
          req_op  = CellDel;
          req_idx = IDX_W'(count_q - 1'b1);
        end
      end
      OpDelAt: begin
        if (del_bad) begin
          req_st = StBadPos;
        end else begin
          req_op  = CellDel;
          req_idx = IDX_W'(pos_w - 1'b1);
        end
      end
      OpReadout: begin
        if (empty) begin
          req_st = StEmpty;
        end
      end
      OpCount: req_st = StOk;
      default: req_st = StOk;
    endcase
  end

  // read-out rotates the list once round, leaving it as it was; else an accepted request's cell command
  always_comb begin
    cell_op  = CellHold;
    cell_idx = '0;
    count_d  = count_q;
    if (step) begin
      cell_op  = CellRot;
      cell_idx = IDX_W'(count_q - 1'b1);
    end else if (acc) begin
      cell_op  = req_op;
      cell_idx = req_idx;
      if (req_op == CellIns) begin
        count_d = count_q + 1'b1;
      end else if (req_op == CellDel) begin
        count_d = count_q - 1'b1;
      end
    end
  end

  assign ins_data = DATA_WIDTH'(in_req_i.value);
  assign head_s   = head_data;

  ple_chain #(
    .CAPACITY   (CAPACITY),
    .IDX_W      (IDX_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_chain (
    .clk_i       (clk_i),
    .op_i        (cell_op),
    .idx_i       (cell_idx),
    .ins_data_i  (ins_data),
    .head_data_o (head_data)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (can_load) begin
        if (step) begin
          out_valid_q <= 1'b1;
          rd_left_q   <= rd_left_q - 1'b1;
          busy_q      <= rd_left_q != CNT_W'(1);
        end else if (acc) begin
          if (in_req_i.operation == OpReadout && !empty) begin
            // no result yet; the first element is registered on the first read-out step
            out_valid_q <= 1'b0;
            busy_q      <= 1'b1;
            rd_left_q   <= count_q;
          end else begin
            out_valid_q <= 1'b1;
          end
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (can_load) begin
      if (step) begin
        out_q.status        <= StOk;
        out_q.element       <= 32'(head_s);
        out_q.element_count <= 7'(count_q);
        out_q.last          <= rd_left_q == CNT_W'(1);
      end else if (acc) begin
        out_q.status        <= req_st;
        out_q.element       <= '0;
        out_q.element_count <= 7'(count_d);
        out_q.last          <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count beyond capacity")
  `PLE_ASSERT_NOW(a_readout_left, busy_q, (rd_left_q != '0) && (rd_left_q <= count_q), "read-out counter out of range")
  `PLE_ASSERT_NEXT(a_insert_grows, acc && (cell_op == CellIns), count_q == $past(count_q) + 1'b1, "insert did not grow the list")
  `PLE_ASSERT_NOW(a_rotate_busy, cell_op == CellRot, busy_q && !acc, "rotation outside read-out")

endmodule

`default_nettype wire
